[hw/rtl/tcw_pkg.sv]
`timescale 1ns / 1ps

package tcw_pkg;

    // Field widths of the channel payloads
    localparam int FUNC_W    = 2;
    localparam int CHAR_W    = 8;
    localparam int IDX_W     = 11;
    localparam int ATTR_W    = 8;
    localparam int CELL_W    = 16;
    localparam int ROW_OUT_W = 5;
    localparam int COL_OUT_W = 7;

    // Item function codes
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // Character codes with special handling
    localparam logic [CHAR_W-1:0] CH_BS        = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PRINT_MAX = 8'h7F;

    // Attribute after reset
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

    // Blank cell for a given attribute
    function automatic logic [CELL_W-1:0] blank_cell(input logic [ATTR_W-1:0] attr);
        blank_cell = {attr, CH_SPACE};
    endfunction

endpackage

[hw/rtl/tcw_if.sv]
`timescale 1ns / 1ps

// Input item channel
interface tcw_in_if;
    import tcw_pkg::*;
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [CHAR_W-1:0]   char_code;
    logic [IDX_W-1:0]    cell_index;

    modport source (output valid, output func, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input func, input char_code, input cell_index,
                    output ready);
endinterface

// Result channel
interface tcw_out_if;
    import tcw_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CELL_W-1:0]    cell_data;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [COL_OUT_W-1:0] cursor_col;

    modport source (output valid, output cell_data, output cursor_row, output cursor_col,
                    input ready);
    modport sink   (input valid, input cell_data, input cursor_row, input cursor_col,
                    output ready);
endinterface

// Attribute register write channel
interface tcw_cfg_if;
    import tcw_pkg::*;
    logic              valid;
    logic              ready;
    logic [ATTR_W-1:0] text_attr;

    modport source (output valid, output text_attr, input ready);
    modport sink   (input valid, input text_attr, output ready);
endinterface

[hw/rtl/text_console_writer.sv]
`timescale 1ns / 1ps
// A put item that does not scroll gives its result in the cycle after acceptance; a read
// passes through S_READ to take the registered store data. A line feed or wrap on the
// last row scrolls, one cell per cycle through the single write port of the cell store.
// Clear blanks the whole store. Items are handled one at a time; the next is taken once
// the result has been taken. Reset: synchronous; a clearing pass then blanks the store
// with attribute 0x0F while no item is accepted; attribute writes are taken throughout.

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tcw_in_if.sink    i_in,
    tcw_out_if.source o_out,
    tcw_cfg_if.sink   i_cfg
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int AW = $clog2(CELL_COUNT);

    logic [ATTR_W-1:0] r_text_attr;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [CELL_W-1:0] wdata;
    logic [AW-1:0]     raddr;
    logic [CELL_W-1:0] rdata;

    // Attribute register, always writable
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attr <= RESET_ATTR;
        end else if (i_cfg.valid) begin
            r_text_attr <= i_cfg.text_attr;
        end
    end

    tcw_ctrl #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP),
        .AW       (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_text_attr (r_text_attr),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata)
    );

    tcw_cell_ram #(
        .DEPTH (CELL_COUNT),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

[hw/rtl/tcw_cell_ram.sv]
`timescale 1ns / 1ps

module tcw_cell_ram
    import tcw_pkg::*;
#(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [CELL_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [CELL_W-1:0] o_rdata
);

    logic [CELL_W-1:0] r_mem [DEPTH];
    logic [CELL_W-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/tcw_ctrl.sv]
`timescale 1ns / 1ps

module tcw_ctrl
    import tcw_pkg::*;
#(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8,
    parameter int AW       = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [ATTR_W-1:0] i_text_attr,
    tcw_in_if.sink            i_in,
    tcw_out_if.source         o_out,
    output logic              o_we,
    output logic [AW-1:0]     o_waddr,
    output logic [CELL_W-1:0] o_wdata,
    output logic [AW-1:0]     o_raddr,
    input  logic [CELL_W-1:0] i_rdata
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int RW  = $clog2(ROWS);
    localparam int CW  = $clog2(COLUMNS);
    localparam int CSW = $clog2(COLUMNS + TAB_STOP);
    localparam int PW  = $clog2(TAB_STOP);
    localparam logic [AW-1:0] LAST_ADDR = AW'(CELL_COUNT - 1);
    localparam logic [AW-1:0] LAST_ROW_ADDR = AW'((ROWS - 1) * COLUMNS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_BLANK
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_addr, n_addr;
    logic [ATTR_W-1:0]   r_fill_attr, n_fill_attr;
    logic                r_clr_cmd, n_clr_cmd;
    logic [RW-1:0]       r_row, n_row;
    logic [CW-1:0]       r_col, n_col;
    logic [PW-1:0]       r_phase, n_phase;
    logic [AW-1:0]       r_base, n_base;
    logic                r_out_valid, n_out_valid;
    logic [CELL_W-1:0]   r_out_data, n_out_data;
    logic                r_wr_pend, n_wr_pend;
    logic [AW-1:0]       r_wr_addr, n_wr_addr;

    logic                in_ready;
    logic                in_accept;
    logic                read_in_range;
    logic                do_nl;
    logic                do_result;
    logic [CW:0]         col_inc;
    logic [CSW-1:0]      tab_col;

    assign in_ready      = (r_state == S_IDLE) && !r_out_valid;
    assign in_accept     = i_in.valid && in_ready;
    assign read_in_range = 32'(i_in.cell_index) < CELL_COUNT;
    assign col_inc       = (CW + 1)'(r_col) + (CW + 1)'(1);
    assign tab_col       = CSW'(r_col) + CSW'(TAB_STOP) - CSW'(r_phase);

    // Sequencer: decode items, step the shared address counter over the store
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_fill_attr = r_fill_attr;
        n_clr_cmd   = r_clr_cmd;
        n_row       = r_row;
        n_col       = r_col;
        n_phase     = r_phase;
        n_base      = r_base;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_wr_pend   = 1'b0;
        n_wr_addr   = r_wr_addr;
        o_we        = 1'b0;
        o_waddr     = r_wr_addr;
        o_wdata     = i_rdata;
        o_raddr     = r_addr;
        do_nl       = 1'b0;
        do_result   = 1'b0;

        // Drop the result once the sink takes it
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        // Finish a pending scroll copy
        if (r_wr_pend) begin
            o_we = 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                o_raddr = AW'(i_in.cell_index);
                if (in_accept) begin
                    n_out_data = '0;
                    unique case (i_in.func)
                        FUNC_PUT: begin
                            case (i_in.char_code) inside
                                CH_LF: begin
                                    do_nl = 1'b1;
                                end
                                CH_CR: begin
                                    n_col     = '0;
                                    n_phase   = '0;
                                    do_result = 1'b1;
                                end
                                CH_TAB: begin
                                    if (tab_col >= CSW'(COLUMNS)) begin
                                        do_nl = 1'b1;
                                    end else begin
                                        n_col     = CW'(tab_col);
                                        n_phase   = '0;
                                        do_result = 1'b1;
                                    end
                                end
                                CH_BS: begin
                                    if (r_col != '0) begin
                                        o_we    = 1'b1;
                                        o_waddr = AW'(r_base + AW'(r_col) - AW'(1));
                                        o_wdata = blank_cell(i_text_attr);
                                        n_col   = CW'(r_col - CW'(1));
                                        n_phase = (r_phase == '0) ? PW'(TAB_STOP - 1)
                                                                  : PW'(r_phase - PW'(1));
                                    end
                                    do_result = 1'b1;
                                end
                                [CH_SPACE:CH_PRINT_MAX]: begin
                                    o_we    = 1'b1;
                                    o_waddr = AW'(r_base + AW'(r_col));
                                    o_wdata = {i_text_attr, i_in.char_code};
                                    if (col_inc >= (CW + 1)'(COLUMNS)) begin
                                        do_nl = 1'b1;
                                    end else begin
                                        n_col     = CW'(col_inc);
                                        n_phase   = (r_phase == PW'(TAB_STOP - 1)) ? '0
                                                    : PW'(r_phase + PW'(1));
                                        do_result = 1'b1;
                                    end
                                end
                                default: begin
                                    do_result = 1'b1;
                                end
                            endcase
                        end
                        FUNC_CLEAR: begin
                            n_fill_attr = i_text_attr;
                            n_addr      = '0;
                            n_clr_cmd   = 1'b1;
                            n_row       = '0;
                            n_col       = '0;
                            n_phase     = '0;
                            n_base      = '0;
                            n_state     = S_CLEAR;
                        end
                        FUNC_READ: begin
                            if (read_in_range) begin
                                n_state = S_READ;
                            end else begin
                                do_result = 1'b1;
                            end
                        end
                        default: begin
                            do_result = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_out_data  = i_rdata;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            S_SCROLL: begin
                // Read one row ahead, write back in the next cycle
                n_wr_pend = 1'b1;
                n_wr_addr = AW'(r_addr - AW'(COLUMNS));
                if (r_addr == LAST_ADDR) begin
                    n_addr  = LAST_ROW_ADDR;
                    n_state = S_BLANK;
                end else begin
                    n_addr = AW'(r_addr + AW'(1));
                end
            end
            S_BLANK: begin
                if (!r_wr_pend) begin
                    o_we    = 1'b1;
                    o_waddr = r_addr;
                    o_wdata = blank_cell(r_fill_attr);
                    if (r_addr == LAST_ADDR) begin
                        n_state     = S_IDLE;
                        n_out_valid = 1'b1;
                        n_out_data  = '0;
                    end else begin
                        n_addr = AW'(r_addr + AW'(1));
                    end
                end
            end
            S_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_addr;
                o_wdata = blank_cell(r_fill_attr);
                if (r_addr == LAST_ADDR) begin
                    n_state   = S_IDLE;
                    n_clr_cmd = 1'b0;
                    if (r_clr_cmd) begin
                        n_out_valid = 1'b1;
                        n_out_data  = '0;
                    end
                end else begin
                    n_addr = AW'(r_addr + AW'(1));
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Advance to the next line, scrolling from the last row
        if (do_nl) begin
            n_col   = '0;
            n_phase = '0;
            if (r_row == RW'(ROWS - 1)) begin
                n_fill_attr = i_text_attr;
                n_addr      = AW'(COLUMNS);
                n_state     = S_SCROLL;
            end else begin
                n_row     = RW'(r_row + RW'(1));
                n_base    = AW'(r_base + AW'(COLUMNS));
                do_result = 1'b1;
            end
        end

        if (do_result) begin
            n_out_valid = 1'b1;
        end
    end

    // Hold state, cursor and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_fill_attr <= RESET_ATTR;
            r_clr_cmd   <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_phase     <= '0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
            r_wr_pend   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_fill_attr <= n_fill_attr;
            r_clr_cmd   <= n_clr_cmd;
            r_row       <= n_row;
            r_col       <= n_col;
            r_phase     <= n_phase;
            r_base      <= n_base;
            r_out_valid <= n_out_valid;
            r_wr_pend   <= n_wr_pend;
        end
        r_out_data <= n_out_data;
        r_wr_addr  <= n_wr_addr;
    end

    assign i_in.ready       = in_ready;
    assign o_out.valid      = r_out_valid;
    assign o_out.cell_data  = r_out_data;
    assign o_out.cursor_row = ROW_OUT_W'(r_row);
    assign o_out.cursor_col = COL_OUT_W'(r_col);

    a_base_tracks_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_base) == 32'(r_row) * COLUMNS)
        else $error("row base out of step with cursor row");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_row) < ROWS) && (32'(r_col) < COLUMNS))
        else $error("cursor outside the screen");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (32'(o_waddr) < CELL_COUNT))
        else $error("cell write beyond the store");

    a_read_goes_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_in.func == FUNC_READ) && read_in_range) |=> (r_state == S_READ))
        else $error("cell read did not wait for memory data");

    a_no_copy_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_wr_pend)
        else $error("scroll copy still pending in idle");

endmodule
